FILE: design/msa_pkg.sv
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants for the matrix slot allocator: command and
// result words, operation codes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package msa_pkg;

    // field widths fixed by the command and result words
    localparam int ID_WIDTH  = 8;
    localparam int MODE_W    = 3;
    localparam int AMOUNT_W  = 7;
    localparam int CFG_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int SIDX_W    = 6;

    // defaults for the top level parameters
    localparam int SLOTS_DEF       = 64;
    localparam int STAMP_WIDTH_DEF = 32;

    // slots_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 3'd0,
        MODE_EVICT   = 3'd1,
        MODE_CLEAR   = 3'd2,
        MODE_SAVE    = 3'd3,
        MODE_RESTORE = 3'd4,
        MODE_FIND    = 3'd5,
        MODE_NTH     = 3'd6,
        MODE_HELD    = 3'd7
    } mode_t;

    // command word
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ID_WIDTH-1:0] matrix_id;
        logic [AMOUNT_W-1:0] amount;
    } cmd_word_t;

    // result word
    typedef struct packed {
        logic                success;
        logic                error_flag;
        logic [SIDX_W-1:0]   slot_index;
        logic [ID_WIDTH-1:0] found_id;
        logic [COUNT_W-1:0]  allocated_count;
        logic [COUNT_W-1:0]  free_count;
    } result_word_t;

endpackage

`default_nettype wire

FILE: design/matrix_slot_allocator_lru_unit.sv
// ----------------------------------------------------------------------------
// matrix_slot_allocator_lru_unit
// Fully associative slot table mapping global matrix ids onto hardware slots,
// with oldest-first eviction and a snapshot copy of the whole table.
// ----------------------------------------------------------------------------
//
//  channel   signals                        handshake
//  --------  -----------------------------  ------------------------------
//  command   start, busy, cmd               taken when start & !busy
//  result    done, result                   one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready, cfg_data written when valid & ready
//
//  Allocate, evict, find, nth and is-held walk the table through one compare
//  unit, one slot per cycle, with a registered memory read in front of it,
//  over n = min(slots_in_use, SLOTS) slots. Evict makes one counting pass
//  and then, if amount is nonzero and no more than the held slots, one pass
//  per slot it evicts. Save and restore walk all SLOTS entries in one memory
//  copy sweep; clear does not walk the table.
//  Reset clears the table at once through per-slot valid bits. The result
//  side cannot stall; a new command is taken in the cycle of the done strobe.
//
`default_nettype none

module matrix_slot_allocator_lru_unit #(
    parameter int SLOTS       = msa_pkg::SLOTS_DEF,
    parameter int STAMP_WIDTH = msa_pkg::STAMP_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire msa_pkg::cmd_word_t          cmd,
    output logic                             done,
    output msa_pkg::result_word_t            result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [msa_pkg::CFG_W-1:0]   cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = ((CNT_W > msa_pkg::COUNT_W) ? CNT_W : msa_pkg::COUNT_W) + 1;
    localparam int TAG_W  = msa_pkg::ID_WIDTH + 1;
    localparam int ENT_W  = TAG_W + STAMP_WIDTH;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_FIN  = 5'b00100,
        ST_COPY = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t                       state_reg, state_next;
    msa_pkg::cmd_word_t           op_reg;
    msa_pkg::mode_t               op_mode;
    logic [msa_pkg::CFG_W-1:0]    slots_cfg_reg;

    // table and snapshot flags, one per slot
    logic [SLOTS-1:0]             busy_reg, tval_reg, sbusy_reg, sval_reg;

    // tag and age memories
    logic [ENT_W-1:0]             tbl_mem [SLOTS];
    logic [ENT_W-1:0]             sav_mem [SLOTS];
    logic [ENT_W-1:0]             trd_reg, srd_reg;
    logic                         rd_valid_reg, rd_busy_reg;

    // walk control
    logic [CNT_W-1:0]             addr_reg, mng;
    logic [SLOT_W-1:0]            raddr, pend_idx_reg;
    logic                         pend_reg, issue, walk_end, start_pass;

    // compare unit results
    logic                         hit_reg, free_found_reg;
    logic [SLOT_W-1:0]            hit_idx_reg, free_idx_reg;
    logic [msa_pkg::ID_WIDTH-1:0] hit_tag_reg;
    logic [STAMP_WIDTH-1:0]       min_age_reg;
    logic [CNT_W-1:0]             rank_reg;
    logic                         evict_phase_reg;
    logic [msa_pkg::AMOUNT_W-1:0] left_reg;

    logic [STAMP_WIDTH-1:0]       stamp_reg;
    logic [msa_pkg::COUNT_W-1:0]  busy_count_reg, saved_count_reg;

    logic                         res_success_reg, res_err_reg;
    logic [msa_pkg::SIDX_W-1:0]   res_sidx_reg;
    logic [msa_pkg::ID_WIDTH-1:0] res_fid_reg;
    logic                         done_reg;
    msa_pkg::result_word_t        result_reg;

    logic                         accept, rescan, too_many;
    logic [TAG_W-1:0]             ent_tag, id_tag;
    logic [STAMP_WIDTH-1:0]       ent_age;
    logic                         alloc_wr, copy_wr, tbl_we, sav_we;
    logic [SLOT_W-1:0]            tbl_waddr;
    logic [ENT_W-1:0]             tbl_wdata;
    logic [CMP_W-1:0]             free_wide;

    // handshake outputs
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign op_mode   = msa_pkg::mode_t'(op_reg.mode);

    // managed slot count
    assign mng = ({2'b00, slots_cfg_reg} < 9'(SLOTS)) ? CNT_W'(slots_cfg_reg) : CNT_W'(SLOTS);

    // walk address issue and end detect
    assign raddr    = addr_reg[SLOT_W-1:0];
    assign issue    = ((state_reg == ST_SCAN) && (addr_reg < mng))
                   || ((state_reg == ST_COPY) && (addr_reg < CNT_W'(SLOTS)));
    assign walk_end = !issue && !pend_reg;

    // entry decode, invalid entries read as all ones
    assign ent_tag = rd_valid_reg ? trd_reg[ENT_W-1 -: TAG_W] : '1;
    assign ent_age = rd_valid_reg ? trd_reg[STAMP_WIDTH-1:0] : '1;
    assign id_tag  = {1'b0, op_reg.matrix_id};

    // eviction checks
    assign too_many = CMP_W'(op_reg.amount) > CMP_W'(rank_reg);
    assign rescan   = (op_mode == msa_pkg::MODE_EVICT)
                   && ((!evict_phase_reg && !too_many && (op_reg.amount != '0))
                       || (evict_phase_reg && (left_reg != 7'd1)));

    // free count for the result word
    assign free_wide = (CMP_W'(mng) > CMP_W'(busy_count_reg))
                     ? CMP_W'(mng) - CMP_W'(busy_count_reg) : '0;

    // memory write selection
    assign alloc_wr  = (state_reg == ST_FIN) && (op_mode == msa_pkg::MODE_ALLOC)
                    && !hit_reg && free_found_reg;
    assign copy_wr   = (state_reg == ST_COPY) && pend_reg;
    assign tbl_we    = alloc_wr || (copy_wr && (op_mode == msa_pkg::MODE_RESTORE));
    assign sav_we    = copy_wr && (op_mode == msa_pkg::MODE_SAVE);
    assign tbl_waddr = alloc_wr ? free_idx_reg : pend_idx_reg;
    assign tbl_wdata = alloc_wr ? {1'b0, op_reg.matrix_id, stamp_reg} : srd_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (msa_pkg::mode_t'(cmd.mode))
                        msa_pkg::MODE_CLEAR:   state_next = ST_RESP;
                        msa_pkg::MODE_SAVE,
                        msa_pkg::MODE_RESTORE: state_next = ST_COPY;
                        default:               state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: if (walk_end) state_next = ST_FIN;
            ST_FIN:  state_next = rescan ? ST_SCAN : ST_RESP;
            ST_COPY: if (walk_end) state_next = ST_RESP;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign start_pass = ((state_next == ST_SCAN) || (state_next == ST_COPY))
                     && (state_next != state_reg);

    // table memory
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        if (issue)
        begin
            trd_reg      <= tbl_mem[raddr];
            rd_busy_reg  <= busy_reg[raddr];
            rd_valid_reg <= tval_reg[raddr];
        end
    end

    // snapshot memory
    always_ff @(posedge clk)
    begin
        if (sav_we)
            sav_mem[pend_idx_reg] <= trd_reg;
        if (issue)
            srd_reg <= sav_mem[raddr];
    end

    // sequencer, compare unit and table control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= '0;
            slots_cfg_reg   <= msa_pkg::CFG_RESET;
            busy_reg        <= '0;
            tval_reg        <= '0;
            sbusy_reg       <= '0;
            sval_reg        <= '0;
            addr_reg        <= '0;
            pend_reg        <= 1'b0;
            pend_idx_reg    <= '0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            hit_idx_reg     <= '0;
            free_idx_reg    <= '0;
            hit_tag_reg     <= '0;
            min_age_reg     <= '0;
            rank_reg        <= '0;
            evict_phase_reg <= 1'b0;
            left_reg        <= '0;
            stamp_reg       <= '0;
            busy_count_reg  <= '0;
            saved_count_reg <= '0;
            res_success_reg <= 1'b0;
            res_err_reg     <= 1'b0;
            res_sidx_reg    <= '0;
            res_fid_reg     <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_RESP);

            // configuration write
            if (cfg_valid && cfg_ready)
                slots_cfg_reg <= cfg_data;

            // command accept
            if (accept)
            begin
                op_reg          <= cmd;
                evict_phase_reg <= 1'b0;
                res_success_reg <= 1'b1;
                res_err_reg     <= 1'b0;
                res_sidx_reg    <= '0;
                res_fid_reg     <= '0;
                unique case (msa_pkg::mode_t'(cmd.mode))
                    msa_pkg::MODE_CLEAR:
                    begin
                        busy_reg       <= '0;
                        tval_reg       <= '0;
                        busy_count_reg <= '0;
                    end
                    msa_pkg::MODE_SAVE:
                    begin
                        sbusy_reg       <= busy_reg;
                        sval_reg        <= tval_reg;
                        saved_count_reg <= busy_count_reg;
                    end
                    msa_pkg::MODE_RESTORE:
                    begin
                        busy_reg       <= sbusy_reg;
                        tval_reg       <= sval_reg;
                        busy_count_reg <= saved_count_reg;
                    end
                    default: ;
                endcase
            end

            // walk address and compare unit
            if (start_pass)
            begin
                addr_reg       <= '0;
                pend_reg       <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                rank_reg       <= '0;
            end
            else if ((state_reg == ST_SCAN) || (state_reg == ST_COPY))
            begin
                pend_reg     <= issue;
                pend_idx_reg <= raddr;
                if (issue)
                    addr_reg <= addr_reg + 1'b1;
                if ((state_reg == ST_SCAN) && pend_reg)
                begin
                    unique case (op_mode)
                        msa_pkg::MODE_ALLOC,
                        msa_pkg::MODE_HELD:
                        begin
                            if (rd_busy_reg && (ent_tag == id_tag))
                                hit_reg <= 1'b1;
                            if (!rd_busy_reg && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= pend_idx_reg;
                            end
                        end
                        msa_pkg::MODE_FIND:
                        begin
                            if ((ent_tag == id_tag) && !hit_reg)
                            begin
                                hit_reg     <= 1'b1;
                                hit_idx_reg <= pend_idx_reg;
                            end
                        end
                        msa_pkg::MODE_NTH:
                        begin
                            if (rd_busy_reg)
                            begin
                                rank_reg <= rank_reg + 1'b1;
                                if (!hit_reg && (CMP_W'(rank_reg) == CMP_W'(op_reg.amount)))
                                begin
                                    hit_reg     <= 1'b1;
                                    hit_tag_reg <= ent_tag[msa_pkg::ID_WIDTH-1:0];
                                end
                            end
                        end
                        msa_pkg::MODE_EVICT:
                        begin
                            if (rd_busy_reg)
                            begin
                                rank_reg <= rank_reg + 1'b1;
                                if (evict_phase_reg && (!hit_reg || (ent_age < min_age_reg)))
                                begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= pend_idx_reg;
                                    min_age_reg <= ent_age;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // finish: act on the walk results
            if (state_reg == ST_FIN)
            begin
                unique case (op_mode)
                    msa_pkg::MODE_ALLOC:
                    begin
                        if (!hit_reg)
                        begin
                            res_success_reg <= free_found_reg;
                            if (free_found_reg)
                            begin
                                busy_reg[free_idx_reg] <= 1'b1;
                                tval_reg[free_idx_reg] <= 1'b1;
                                stamp_reg              <= stamp_reg + 1'b1;
                                if (busy_count_reg != '1)
                                    busy_count_reg <= busy_count_reg + 1'b1;
                            end
                        end
                    end
                    msa_pkg::MODE_EVICT:
                    begin
                        if (!evict_phase_reg)
                        begin
                            if (too_many)
                            begin
                                res_success_reg <= 1'b0;
                                res_err_reg     <= 1'b1;
                            end
                            evict_phase_reg <= 1'b1;
                            left_reg        <= op_reg.amount;
                        end
                        else
                        begin
                            if (hit_reg)
                            begin
                                busy_reg[hit_idx_reg] <= 1'b0;
                                if (busy_count_reg != '0)
                                    busy_count_reg <= busy_count_reg - 1'b1;
                            end
                            left_reg <= left_reg - 1'b1;
                        end
                    end
                    msa_pkg::MODE_FIND:
                    begin
                        res_success_reg <= hit_reg;
                        res_err_reg     <= !hit_reg;
                        res_sidx_reg    <= hit_reg ? msa_pkg::SIDX_W'(hit_idx_reg) : '0;
                    end
                    msa_pkg::MODE_NTH:
                    begin
                        res_success_reg <= hit_reg;
                        res_err_reg     <= !hit_reg;
                        res_fid_reg     <= hit_reg ? hit_tag_reg : '0;
                    end
                    msa_pkg::MODE_HELD:
                        res_success_reg <= hit_reg;
                    default: ;
                endcase
            end

            // result word
            if (state_reg == ST_RESP)
            begin
                result_reg.success         <= res_success_reg;
                result_reg.error_flag      <= res_err_reg;
                result_reg.slot_index      <= res_sidx_reg;
                result_reg.found_id        <= res_fid_reg;
                result_reg.allocated_count <= busy_count_reg;
                result_reg.free_count      <= free_wide[msa_pkg::COUNT_W-1:0];
            end
        end
    end

    // checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken without going busy");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (SLOTS > 127) || (busy_count_reg == msa_pkg::COUNT_W'($countones(busy_reg))))
        else $error("allocated count out of step with busy flags");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("read pending while idle");

    a_evict_left: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && evict_phase_reg) |-> (left_reg != '0))
        else $error("eviction pass with nothing left to evict");

endmodule

`default_nettype wire
